// ===== sv/lcn_pkg.sv =====
`default_nettype none

package lcn_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LinePosW = 4;
  localparam int unsigned TargetW  = 3;
  localparam int unsigned ValueW   = 36;

  localparam logic [ByteW-1:0]  NewlineByte = 8'h0A;
  localparam logic [ByteW-1:0]  ColonByte   = 8'h3A;
  localparam logic [ValueW-1:0] DigitZero   = 36'd48;

  localparam logic [ByteW-1:0] LetterQ = 8'h51;
  localparam logic [ByteW-1:0] LetterW = 8'h57;
  localparam logic [ByteW-1:0] LetterP = 8'h50;
  localparam logic [ByteW-1:0] LetterI = 8'h49;
  localparam logic [ByteW-1:0] LetterD = 8'h44;

  typedef enum logic [TargetW-1:0] {
    TgtSetpoint   = 3'd0,
    TgtMotorSpeed = 3'd1,
    TgtKp         = 3'd2,
    TgtKi         = 3'd3,
    TgtKd         = 3'd4
  } target_e;

  // Staged input item handed from the input register to the parser.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  // Line state exported for checking at the top level.
  typedef struct packed {
    logic                take;
    logic                newline;
    logic [LinePosW-1:0] line_pos;
    logic                too_long;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/lcn_if.sv =====
`default_nettype none

interface lcn_byte_if;
  import lcn_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcn_cmd_if;
  import lcn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TargetW-1:0]       target;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output target, output value, input ready);
  modport sink   (input valid, input target, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/lcn_in_stage.sv =====
`default_nettype none

module lcn_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lcn_byte_if.sink           rx_i,
  input  wire logic          down_ready_i,
  output lcn_pkg::item_t     item_o
);
  import lcn_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             load;

  // Refill the register whenever it is empty or its item moves on.
  assign rx_i.ready = !valid_q || down_ready_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = rx_i.rx_byte;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_o.valid   = valid_q;
  assign item_o.rx_byte = byte_q;

endmodule

`default_nettype wire

// ===== sv/lcn_line_parse.sv =====
`default_nettype none

module lcn_line_parse #(
  parameter int unsigned LINE_MAX = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lcn_pkg::item_t item_i,
  output logic               ready_o,
  lcn_cmd_if.source          res_o,
  output lcn_pkg::status_t   status_o
);
  import lcn_pkg::*;

  localparam logic [LinePosW-1:0] PosLimit = LinePosW'(LINE_MAX - 1);

  logic [LinePosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0]    letter_q, letter_d;
  logic                sep_q, sep_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic                long_q, long_d;

  logic                res_v_q, res_v_d;
  logic [TargetW-1:0]  res_tgt_q, res_tgt_d;
  logic [ValueW-1:0]   res_val_q, res_val_d;

  logic                take;
  logic                is_nl;
  logic                letter_ok;
  target_e             tgt;
  logic [ValueW-1:0]   acc_next;
  logic [ValueW-1:0]   byte_ext;

  // Only advance when the result register can take a new result.
  assign ready_o = !res_v_q || res_o.ready;
  assign take    = item_i.valid && ready_o;
  assign is_nl   = (item_i.rx_byte == NewlineByte);

  always_comb begin
    letter_ok = 1'b1;
    tgt       = TgtSetpoint;
    case (letter_q)
      LetterQ: tgt = TgtSetpoint;
      LetterW: tgt = TgtMotorSpeed;
      LetterP: tgt = TgtKp;
      LetterI: tgt = TgtKi;
      LetterD: tgt = TgtKd;
      default: letter_ok = 1'b0;
    endcase
  end

  // value * 10 as two shifts, plus the offset of the byte from '0', mod 2^36
  assign byte_ext = {{(ValueW-ByteW){1'b0}}, item_i.rx_byte};
  assign acc_next = (acc_q << 3) + (acc_q << 1) + byte_ext - DigitZero;

  always_comb begin
    pos_d     = pos_q;
    letter_d  = letter_q;
    sep_d     = sep_q;
    acc_d     = acc_q;
    long_d    = long_q;
    res_v_d   = res_v_q && !res_o.ready;
    res_tgt_d = res_tgt_q;
    res_val_d = res_val_q;
    if (take) begin
      if (is_nl) begin
        if (!long_q && pos_q >= LinePosW'(2) && sep_q && letter_ok) begin
          res_v_d   = 1'b1;
          res_tgt_d = tgt;
          res_val_d = acc_q;
        end
        pos_d    = '0;
        letter_d = '0;
        sep_d    = 1'b0;
        acc_d    = '0;
        long_d   = 1'b0;
      end else if (!long_q) begin
        if (pos_q >= PosLimit) begin
          // Drop the rest of the line up to its newline.
          long_d = 1'b1;
        end else begin
          case (pos_q)
            LinePosW'(0): letter_d = item_i.rx_byte;
            LinePosW'(1): sep_d    = (item_i.rx_byte == ColonByte);
            default:      acc_d    = acc_next;
          endcase
          pos_d = pos_q + LinePosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      letter_q <= '0;
      sep_q    <= 1'b0;
      acc_q    <= '0;
      long_q   <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      letter_q <= letter_d;
      sep_q    <= sep_d;
      acc_q    <= acc_d;
      long_q   <= long_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_tgt_q <= res_tgt_d;
    res_val_q <= res_val_d;
  end

  assign res_o.valid  = res_v_q;
  assign res_o.target = res_tgt_q;
  assign res_o.value  = res_val_q;

  assign status_o.take     = take;
  assign status_o.newline  = is_nl;
  assign status_o.line_pos = pos_q;
  assign status_o.too_long = long_q;

endmodule

`default_nettype wire

// ===== sv/letter_colon_number_command_parser_core.sv =====
// Channel  Dir  Payload                        Accepted when
// rx_i     in   rx_byte[7:0]                   rx_i.valid && rx_i.ready
// res_o    out  target[2:0], value[35:0] s     res_o.valid && res_o.ready
//
// One byte per cycle sustained while res_o is not stalled. A byte is registered
// in the input register on entry and parsed once the parser takes it; its
// result, if any, is loaded into the result register. Reset clears the line
// state and both valid flags. A stalled result holds the parser and, once the
// input register is full, rx_i.ready drops in the same cycle.
`default_nettype none

module letter_colon_number_command_parser_core #(
  parameter int unsigned LINE_MAX = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lcn_byte_if.sink  rx_i,
  lcn_cmd_if.source res_o
);
  import lcn_pkg::*;

  localparam logic [LinePosW-1:0] PosLimit = LinePosW'(LINE_MAX - 1);

  item_t   item;
  logic    parse_ready;
  status_t status;

  lcn_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .down_ready_i (parse_ready),
    .item_o       (item)
  );

  lcn_line_parse #(
    .LINE_MAX (LINE_MAX)
  ) u_line_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .ready_o  (parse_ready),
    .res_o    (res_o),
    .status_o (status)
  );

  a_res_from_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(status.take && status.newline))
    else $error("result appeared without a parsed newline");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.line_pos <= PosLimit)
    else $error("line position beyond limit");

  a_long_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.too_long |-> status.line_pos == PosLimit)
    else $error("overlong flag set before the line filled");

  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.take && status.newline |=> status.line_pos == '0 && !status.too_long)
    else $error("newline did not clear the line state");

endmodule

`default_nettype wire
